>>> rtl/core/tpo_pkg.sv
// Shared codes, limits and types for the tape playback oscillator.
`default_nettype none

package tpo_pkg;

	// func field codes
	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_REWIND = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_BUFFER_FRAMES = 3'd0;
	localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd1;
	localparam logic [2:0] CFG_LOOP_RANGE    = 3'd2;
	localparam logic [2:0] CFG_START_OFFSET  = 3'd3;
	localparam logic [2:0] CFG_SPEED         = 3'd4;

	// largest value a 13-bit frame count register can hold
	localparam int CFG_FRAMES_MAX = 8191;
	// integer bits of the Q13.16 speed register (29 bits wide)
	localparam int SPEED_INT_W = 13;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/tpo_modulo.sv
// Iterative remainder unit: one dividend bit per cycle, restoring subtract.
`default_nettype none

module tpo_modulo #(
	parameter int NUM_W = 14,
	parameter int DIV_W = 13
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NUM_W-1:0]  dividend,
	input  wire logic [DIV_W-1:0]  divisor,
	output tpo_pkg::mod_sts_t      sts,
	output logic      [DIV_W-1:0]  rem
);
	import tpo_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [NUM_W-1:0] dvd_q;
	logic [DIV_W-1:0] div_q;

	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   trial;
	logic [DIV_W-1:0] rem_nxt;

	always_comb begin
		shifted = {rem_q, dvd_q[NUM_W-1]};
		trial   = shifted - {1'b0, div_q};
		// remainder stays below the divisor, so the result fits DIV_W bits
		if (shifted >= {1'b0, div_q}) begin
			rem_nxt = trial[DIV_W-1:0];
		end else begin
			rem_nxt = shifted[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_q << 1;
		end else if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem      = rem_q;

endmodule

`default_nettype wire

>>> rtl/core/tape_playback_oscillator.sv
// Tape playback oscillator: interleaved sample store, phase wrap, interpolation, gain.
// Load and rewind words never stall the input. A tick stalls it while the bit-serial
// remainder unit (NW-bit dividends, NW = 14 at default sizes) and one shared multiplier
// (two products per channel) produce one word for each channel of the clamped count.
// The next word is taken once the last result of a tick is in the output register.
// Reset clears the phase and control and restores the register defaults; the store is kept.
`default_nettype none

module tape_playback_oscillator #(
	parameter int MAX_FRAMES   = 4096,
	parameter int MAX_CHANNELS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [28:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [1:0]  func,
	input  wire logic        [14:0] sample_index,
	input  wire logic signed [15:0] sample_value,
	input  wire logic        [15:0] amp_gain,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed      [15:0] sample_out,
	output logic             [2:0]  channel,
	output logic                    gate,
	output logic                    last
);
	import tpo_pkg::*;

	localparam int LIM   = (MAX_FRAMES < CFG_FRAMES_MAX) ? MAX_FRAMES : CFG_FRAMES_MAX;
	localparam int IW    = $clog2(LIM);
	localparam int DW    = $clog2(LIM + 1);
	localparam int NW    = ((IW > SPEED_INT_W) ? IW : SPEED_INT_W) + 1;
	localparam int SW    = NW + 16;
	localparam int ACC_W = IW + 16;
	localparam int CHW   = $clog2(MAX_CHANNELS + 1);
	localparam int DEPTH = MAX_FRAMES * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_POSDIV  = 9'b000000010,
		ST_STEPDIV = 9'b000000100,
		ST_BASE    = 9'b000001000,
		ST_RD_A    = 9'b000010000,
		ST_RD_B    = 9'b000100000,
		ST_MUL1    = 9'b001000000,
		ST_MUL2    = 9'b010000000,
		ST_EMIT    = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [12:0] frames_cfg_q;
	logic [3:0]  chans_cfg_q;
	logic [12:0] range_cfg_q;
	logic [27:0] start_q;
	logic [28:0] speed_q;

	// phase and per-tick context
	logic [ACC_W-1:0] acc_q;
	logic [IW-1:0]    frame_q;
	logic [15:0]      frac_q;
	logic [15:0]      step_frac_q;
	logic [15:0]      gain_q;
	logic             gate_q;
	logic [AW-1:0]    base_q;
	logic [CHW-1:0]   chan_q;

	// datapath
	logic        [15:0] rdata_q;
	logic signed [15:0] a_q;
	logic signed [49:0] prod_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic        [2:0]  out_chan_q;
	logic               out_gate_q;
	logic               out_last_q;

	// sample store
	logic [15:0] store_mem [DEPTH];

	logic [DW-1:0]  frames_m1;
	logic [DW-1:0]  range_c;
	logic [CHW-1:0] chans_c;

	logic           in_acc;
	logic           emit_go;
	logic           chan_last;
	logic [SW-1:0]  pos_sum;
	logic [SW-1:0]  step_sum;

	logic           mod_start;
	logic [NW-1:0]  mod_dvd;
	logic [DW-1:0]  mod_div;
	logic [DW-1:0]  mod_rem;
	mod_sts_t       mod_sts;

	logic [AW-1:0]  addr_a;
	logic [AW-1:0]  addr_b;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic           wr_en;

	logic signed [16:0] diff;
	logic signed [33:0] interp34;
	logic signed [31:0] interp;
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [49:0] rnd;
	logic signed [19:0] shv;
	logic signed [15:0] sat;

	// register clamps
	always_comb begin
		if (frames_cfg_q < 13'd2) begin
			frames_m1 = DW'(1);
		end else if (32'(frames_cfg_q) > LIM) begin
			frames_m1 = DW'(LIM - 1);
		end else begin
			frames_m1 = DW'(frames_cfg_q - 13'd1);
		end

		if (range_cfg_q == 13'd0) begin
			range_c = DW'(1);
		end else if (32'(range_cfg_q) > LIM) begin
			range_c = DW'(LIM);
		end else begin
			range_c = DW'(range_cfg_q);
		end

		if (chans_cfg_q == 4'd0) begin
			chans_c = CHW'(1);
		end else if (32'(chans_cfg_q) > MAX_CHANNELS) begin
			chans_c = CHW'(MAX_CHANNELS);
		end else begin
			chans_c = CHW'(chans_cfg_q);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign emit_go   = !out_valid_q || !out_stall;
	assign chan_last = (chan_q == chans_c - CHW'(1));

	assign pos_sum  = SW'(acc_q) + SW'(start_q);
	assign step_sum = SW'(acc_q) + SW'(speed_q);

	// shared remainder unit: read position first, then phase wrap
	assign mod_start = (in_acc && func == FUNC_TICK) || (state_q == ST_POSDIV && mod_sts.done);
	assign mod_dvd   = (state_q == ST_IDLE) ? pos_sum[SW-1:16] : step_sum[SW-1:16];
	assign mod_div   = (state_q == ST_IDLE) ? frames_m1 : range_c;

	tpo_modulo #(
		.NUM_W (NW),
		.DIV_W (DW)
	) u_modulo (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dvd),
		.divisor  (mod_div),
		.sts      (mod_sts),
		.rem      (mod_rem)
	);

	// store addresses
	assign addr_a  = base_q + AW'(chan_q);
	assign addr_b  = addr_a + AW'(chans_c);
	assign rd_en   = (state_q == ST_RD_A) || (state_q == ST_RD_B);
	assign rd_addr = (state_q == ST_RD_B) ? addr_b : addr_a;
	assign wr_en   = in_acc && (func == FUNC_LOAD) && (32'(sample_index) < DEPTH);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[AW'(sample_index)] <= sample_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= store_mem[rd_addr];
		end
	end

	// shared multiplier: frame*channels, then (b-a)*f, then interp*gain
	assign diff     = $signed({rdata_q[15], rdata_q}) - $signed({a_q[15], a_q});
	assign interp34 = $signed({{2{a_q[15]}}, a_q, 16'h0000}) + prod_q[33:0];
	assign interp   = interp34[31:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_BASE: begin
				mul_a = 33'(frame_q);
				mul_b = 17'(chans_c);
			end
			ST_MUL1: begin
				mul_a = {{16{diff[16]}}, diff};
				mul_b = {1'b0, frac_q};
			end
			ST_MUL2: begin
				mul_a = {interp[31], interp};
				mul_b = {1'b0, gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// round half up at bit 30, then saturate to 16 bits
	assign rnd = prod_q + 50'sd536870912;
	assign shv = 20'(rnd >>> 30);

	always_comb begin
		if (shv > 20'sd32767) begin
			sat = 16'sh7FFF;
		end else if (shv < -20'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = shv[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_cfg_q <= 13'd4096;
			chans_cfg_q  <= 4'd1;
			range_cfg_q  <= 13'd4096;
			start_q      <= 28'd0;
			speed_q      <= 29'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BUFFER_FRAMES: frames_cfg_q <= cfg_wdata[12:0];
				CFG_CHANNEL_COUNT: chans_cfg_q  <= cfg_wdata[3:0];
				CFG_LOOP_RANGE:    range_cfg_q  <= cfg_wdata[12:0];
				CFG_START_OFFSET:  start_q      <= cfg_wdata[27:0];
				CFG_SPEED:         speed_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			chan_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (func)
							FUNC_TICK:   state_q <= ST_POSDIV;
							FUNC_REWIND: acc_q   <= '0;
							default: ;
						endcase
					end
				end
				ST_POSDIV: begin
					if (mod_sts.done) begin
						state_q <= ST_STEPDIV;
					end
				end
				ST_STEPDIV: begin
					if (mod_sts.done) begin
						acc_q   <= {IW'(mod_rem), step_frac_q};
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					chan_q  <= '0;
					state_q <= ST_RD_A;
				end
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_go) begin
						if (chan_last) begin
							state_q <= ST_IDLE;
						end else begin
							chan_q  <= chan_q + CHW'(1);
							state_q <= ST_RD_A;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-tick payload
	always_ff @(posedge clk) begin
		if (in_acc && func == FUNC_TICK) begin
			frac_q <= pos_sum[15:0];
			gain_q <= amp_gain;
		end
		if (state_q == ST_POSDIV && mod_sts.done) begin
			frame_q     <= IW'(mod_rem);
			step_frac_q <= step_sum[15:0];
			gate_q      <= (step_sum[SW-1:16] >= NW'(range_c));
		end
		if (state_q == ST_BASE) begin
			base_q <= AW'(mul_p);
		end
		if (state_q == ST_RD_B) begin
			a_q <= rdata_q;
		end
		if (state_q == ST_MUL1 || state_q == ST_MUL2) begin
			prod_q <= mul_p;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_go) begin
			out_sample_q <= sat;
			out_chan_q   <= 3'(chan_q);
			out_gate_q   <= gate_q;
			out_last_q   <= chan_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_sample_q;
	assign channel    = out_chan_q;
	assign gate       = out_gate_q;
	assign last       = out_last_q;

	// checks
	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("result word appeared outside emit");

	a_div_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		mod_sts.done |-> (state_q == ST_POSDIV || state_q == ST_STEPDIV))
		else $error("remainder finished with no consumer");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POSDIV || state_q == ST_STEPDIV) |-> (mod_sts.busy || mod_sts.done))
		else $error("sequencer waiting on an idle remainder unit");

	a_frame_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BASE |-> DW'(frame_q) < frames_m1)
		else $error("read frame beyond wrap point");

endmodule

`default_nettype wire

>>> test/tpo_checker.sv
// Scoreboard for the tape playback oscillator: mirrors its state and checks every output word.
module tpo_checker
	import tpo_pkg::*;
#(
	parameter int MAX_FRAMES   = 4096,
	parameter int MAX_CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [28:0] cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic        [1:0]  func,
	input  logic        [14:0] sample_index,
	input  logic signed [15:0] sample_value,
	input  logic        [15:0] amp_gain,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] sample_out,
	input  logic        [2:0]  channel,
	input  logic               gate,
	input  logic               last,
	output int                 errors,
	output int                 pending,
	output int                 voices_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = MAX_FRAMES * MAX_CHANNELS;
	localparam longint ROUND_HALF = 64'sd536870912;

	typedef struct {
		logic signed [15:0] smp;
		logic        [2:0]  chan;
		logic               gate;
		logic               last;
	} voice_t;

	logic signed [15:0] store [STORE_DEPTH];
	logic [12:0] reg_frames;
	logic [3:0]  reg_chans;
	logic [12:0] reg_span;
	logic [27:0] reg_start;
	logic [28:0] reg_speed;
	longint      phase;
	voice_t      voice_q [$];

	task automatic report(input string msg);
		errors++;
		if (errors <= 100)
			$display("%0t ps mismatch: %s", $realtime * 1000, msg);
	endtask

	// one tick: read position, advance phase, queue one voice per channel
	function automatic void render_tick(input logic [15:0] gain);
		longint frames, chans, span, wrap_len, pos, frm, frac, sum;
		longint a, b, mix, prod, r;
		longint c;
		logic hit;
		voice_t v;
		frames = reg_frames;
		if (frames < 2) frames = 2;
		if (frames > MAX_FRAMES) frames = MAX_FRAMES;
		chans = reg_chans;
		if (chans < 1) chans = 1;
		if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;
		span = reg_span;
		if (span < 1) span = 1;
		if (span > MAX_FRAMES) span = MAX_FRAMES;

		wrap_len = (frames - 1) << 16;
		pos = (phase + longint'(reg_start)) % wrap_len;
		frm = pos >> 16;
		frac = pos & 64'hFFFF;

		sum = phase + longint'(reg_speed);
		hit = (sum >= (span << 16));
		phase = sum % (span << 16);

		for (c = 0; c < chans; c++) begin
			a = store[int'((frm * chans + c) % STORE_DEPTH)];
			b = store[int'(((frm + 1) * chans + c) % STORE_DEPTH)];
			mix = a * (65536 - frac) + b * frac;
			prod = mix * longint'(gain);
			r = (prod + ROUND_HALF) >>> 30;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			v.smp = r[15:0];
			v.chan = c[2:0];
			v.gate = hit;
			v.last = (c == chans - 1);
			voice_q.push_back(v);
		end
	endfunction

	task automatic check_voice();
		voice_t want;
		voices_seen++;
		if (voice_q.size() == 0) begin
			report($sformatf("word with nothing expected: sample %0d channel %0d",
				sample_out, channel));
			return;
		end
		want = voice_q.pop_front();
		if (sample_out !== want.smp)
			report($sformatf("sample_out %0d, expected %0d (channel %0d)",
				sample_out, want.smp, want.chan));
		if (channel !== want.chan)
			report($sformatf("channel %0d, expected %0d", channel, want.chan));
		if (gate !== want.gate)
			report($sformatf("gate %0b, expected %0b (channel %0d)", gate, want.gate, want.chan));
		if (last !== want.last)
			report($sformatf("last %0b, expected %0b (channel %0d)", last, want.last, want.chan));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_frames = 13'd4096;
			reg_chans = 4'd1;
			reg_span = 13'd4096;
			reg_start = '0;
			reg_speed = 29'd65536;
			phase = 0;
			voice_q.delete();
			pending = 0;
			errors = 0;
			voices_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BUFFER_FRAMES: reg_frames = cfg_wdata[12:0];
					CFG_CHANNEL_COUNT: reg_chans = cfg_wdata[3:0];
					CFG_LOOP_RANGE:    reg_span = cfg_wdata[12:0];
					CFG_START_OFFSET:  reg_start = cfg_wdata[27:0];
					CFG_SPEED:         reg_speed = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (func)
					FUNC_LOAD: begin
						if (sample_index < STORE_DEPTH)
							store[sample_index] = sample_value;
					end
					FUNC_TICK:   render_tick(amp_gain);
					FUNC_REWIND: phase = 0;
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				check_voice();
			pending = voice_q.size();
		end
	end

endmodule

>>> test/tb_top.sv
// Testbench top for the tape playback oscillator: stimulus, idling, watchdog and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tpo_pkg::*;

	localparam int FRAMES_CAP    = 4096;
	localparam int CHANNELS_CAP  = 8;
	localparam int STORE_WORDS   = FRAMES_CAP * CHANNELS_CAP;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 3000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 24;
	localparam int NEAR_ENTRIES  = 16;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic        [2:0]  cfg_index = CFG_BUFFER_FRAMES;
	logic        [28:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic        [1:0]  func = FUNC_LOAD;
	logic        [14:0] sample_index = '0;
	logic signed [15:0] sample_value = '0;
	logic        [15:0] amp_gain = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] sample_out;
	logic        [2:0]  channel;
	logic               gate;
	logic               last;

	int errors, pending, voices_seen;
	int quiet = 0;
	int n_ticks = 0, n_loads = 0, n_rewinds = 0, n_settings = 0;
	int frames_eff = FRAMES_CAP, chans_eff = 1;
	bit tx_idle = 1'b1, rx_idle = 1'b1, hold_req = 1'b0;
	bit written [STORE_WORDS];

	always #1 clk = ~clk;

	tape_playback_oscillator #(
		.MAX_FRAMES(FRAMES_CAP),
		.MAX_CHANNELS(CHANNELS_CAP)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .sample_index(sample_index), .sample_value(sample_value),
		.amp_gain(amp_gain),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out), .channel(channel), .gate(gate), .last(last)
	);

	tpo_checker #(
		.MAX_FRAMES(FRAMES_CAP),
		.MAX_CHANNELS(CHANNELS_CAP)
	) i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .sample_index(sample_index), .sample_value(sample_value),
		.amp_gain(amp_gain),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out), .channel(channel), .gate(gate), .last(last),
		.errors(errors), .pending(pending), .voices_seen(voices_seen)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : rx_side
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// returns on the edge that takes the word; valid is left high
	task automatic push_word(input logic [1:0] f, input logic [14:0] idx,
			input logic [15:0] val, input logic [15:0] gain);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		sample_index <= idx;
		sample_value <= val;
		amp_gain <= gain;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic load_word(input logic [14:0] idx, input logic [15:0] val);
		push_word(FUNC_LOAD, idx, val, 16'($urandom));
		written[idx] = 1'b1;
		n_loads++;
	endtask

	task automatic tick_word(input logic [15:0] gain);
		push_word(FUNC_TICK, 15'($urandom), 16'($urandom), gain);
		n_ticks++;
	endtask

	task automatic rewind_word();
		push_word(FUNC_REWIND, 15'($urandom), 16'($urandom), 16'($urandom));
		n_rewinds++;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'hFFFF;
			1: return 16'd16384;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 20000));
		endcase
	endfunction

	// every entry the coming ticks can reach must hold a sample
	task automatic fill_store(input int entries);
		for (int i = 0; i < entries; i++)
			if (!written[i]) load_word(15'(i), pick_sample());
	endtask

	// wait for the last expected word, then let any word in flight finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [12:0] fr, input logic [3:0] ch,
			input logic [12:0] rg, input logic [27:0] st, input logic [28:0] sp);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BUFFER_FRAMES;
		cfg_wdata <= 29'(fr);
		@(posedge clk);
		cfg_index <= CFG_CHANNEL_COUNT;
		cfg_wdata <= 29'(ch);
		@(posedge clk);
		cfg_index <= CFG_LOOP_RANGE;
		cfg_wdata <= 29'(rg);
		@(posedge clk);
		cfg_index <= CFG_START_OFFSET;
		cfg_wdata <= 29'(st);
		@(posedge clk);
		cfg_index <= CFG_SPEED;
		cfg_wdata <= sp;
		@(posedge clk);
		cfg_we <= 1'b0;
		frames_eff = (fr < 2) ? 2 : (fr > FRAMES_CAP) ? FRAMES_CAP : int'(fr);
		chans_eff = (ch < 1) ? 1 : (ch > CHANNELS_CAP) ? CHANNELS_CAP : int'(ch);
		n_settings++;
	endtask

	task automatic random_setting();
		logic [12:0] fr, rg;
		logic [3:0] ch;
		logic [27:0] st;
		logic [28:0] sp;
		int span;
		case ($urandom_range(0, 5))
			0: begin
				fr = 13'($urandom_range(2, 64));
				ch = 4'd1;
			end
			1: begin
				fr = 13'($urandom_range(0, 1));
				ch = 4'($urandom_range(9, 15));
			end
			default: begin
				fr = 13'($urandom_range(2, 8));
				ch = 4'($urandom_range(0, CHANNELS_CAP));
			end
		endcase
		if ($urandom_range(0, 3) == 0)
			rg = 13'($urandom_range(0, 8191));
		else
			rg = 13'($urandom_range(1, 64));
		span = (rg < 1) ? 1 : (rg > FRAMES_CAP) ? FRAMES_CAP : int'(rg);
		st = 28'($urandom);
		case ($urandom_range(0, 5))
			0: sp = '0;
			1: sp = 29'($urandom);
			default: sp = 29'($urandom_range(0, span << 16));
		endcase
		write_regs(fr, ch, rg, st, sp);
	endtask

	task automatic random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			tick_word(pick_gain());
		else if (pick < 72)
			load_word(15'($urandom_range(0, frames_eff * chans_eff - 1)), pick_sample());
		else if (pick < 76)
			load_word(15'($urandom), 16'($urandom));
		else if (pick < 88)
			rewind_word();
		else if (pick < 93)
			push_word(FUNC_UNUSED, 15'($urandom), 16'($urandom), 16'($urandom));
		else
			tick_word(16'hFFFF);
	endtask

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: full-length store, one channel, unit speed; ticks stay near the start
		fill_store(NEAR_ENTRIES);
		rewind_word();
		load_word(15'd0, 16'h8000);
		load_word(15'd1, 16'h7FFF);
		tick_word(16'hFFFF);
		tick_word(16'hFFFF);
		tick_word(16'd0);
		tick_word(16'd16384);
		push_word(FUNC_UNUSED, 15'h7FFF, 16'hFFFF, 16'hFFFF);
		rewind_word();
		tick_word(16'd16384);
		load_word(15'h7FFF, pick_sample());
		tick_word(pick_gain());

		// registers below their floors, fastest speed, top start offset
		drain();
		write_regs(13'd1, 4'd0, 13'd0, 28'hFFFFFFF, 29'h1FFFFFFF);
		fill_store(frames_eff * chans_eff);
		repeat (4) tick_word(pick_gain());

		// frame count and loop range above their ceilings, one channel, speed equal to the whole range; the phase
		// stays put, so reads sit at the start offset within the first few frames
		drain();
		write_regs(13'd8191, 4'd1, 13'd8191, 28'($urandom_range(0, 32'h7FFFF)), 29'h10000000);
		fill_store(NEAR_ENTRIES);
		rewind_word();
		repeat (4) tick_word(pick_gain());

		// widest frame: channel count clamped to the maximum
		drain();
		write_regs(13'd3, 4'd15, 13'd2, 28'd0, 29'h18000);
		fill_store(frames_eff * chans_eff);
		repeat (4) tick_word(pick_gain());
		rewind_word();
		tick_word(16'hFFFF);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			random_setting();
			fill_store(frames_eff * chans_eff);
			if (p == RANDOM_PHASES - 1) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			if (p == 2)
				hold_req = 1'b1;
			repeat (PHASE_WORDS) random_word();
		end

		drain();
		$display("covered %0d ticks, %0d loads, %0d rewinds under %0d register settings;",
			n_ticks, n_loads, n_rewinds, n_settings);
		$display("%0d output words checked, %0d mismatches", voices_seen, errors);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
